@@ src/kplc_pkg.sv @@
package kplc_pkg;

	localparam int PIN_DIGITS = 4;
	localparam int CNT_W      = $clog2(PIN_DIGITS + 1);
	localparam int SLOTS      = (PIN_DIGITS < 4) ? PIN_DIGITS : 4;

	typedef enum logic [3:0] {
		EV_NONE    = 4'd0,
		EV_EDIT    = 4'd1,
		EV_GRANT   = 4'd2,
		EV_DENY    = 4'd3,
		EV_SAVE    = 4'd4,
		EV_LOCK    = 4'd5,
		EV_UNLOCK  = 4'd6,
		EV_SETMODE = 4'd7,
		EV_CLEAR   = 4'd8,
		EV_ZERO    = 4'd9,
		EV_IGNORED = 4'd10
	} event_t;

	typedef enum logic [2:0] {
		SND_NONE    = 3'd0,
		SND_CLICK   = 3'd1,
		SND_CONFIRM = 3'd2,
		SND_SET     = 3'd3,
		SND_DOUBLE  = 3'd4,
		SND_WRONG   = 3'd5,
		SND_MELODY  = 3'd6
	} sound_t;

	// key codes; 0 to 9 are digits
	localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
	localparam logic [3:0] KEY_OK        = 4'd10;
	localparam logic [3:0] KEY_SET       = 4'd11;
	localparam logic [3:0] KEY_CLR       = 4'd12;
	localparam logic [3:0] KEY_DEL       = 4'd13;

	localparam logic FUNC_TICK = 1'b1;

	typedef enum logic [1:0] {
		REG_LOCKOUT_SECONDS  = 2'd0,
		REG_FAILURE_LIMIT    = 2'd1,
		REG_LED_HOLD_MS      = 2'd2,
		REG_TICKS_PER_SECOND = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0]  lockout_seconds;
		logic [3:0]  failure_limit;
		logic [15:0] led_hold_ms;
		logic [15:0] ticks_per_second;
	} cfg_t;

	typedef struct packed {
		event_t      ev;
		sound_t      snd;
		logic        led_lit;
		logic        locked;
		logic [7:0]  seconds_left;
		logic [2:0]  entered_count;
		logic [15:0] entered_digits;
		logic        in_set_mode;
		logic [3:0]  failures;
	} result_t;

endpackage

@@ src/kplc_cfg.sv @@
module kplc_cfg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_valid,
	input  logic [1:0]     cfg_index,
	input  logic [15:0]    cfg_data,
	output logic           cfg_ready,
	output kplc_pkg::cfg_t cfg
);
	import kplc_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lockout_seconds  <= 8'd10;
			cfg_q.failure_limit    <= 4'd3;
			cfg_q.led_hold_ms      <= 16'd1200;
			cfg_q.ticks_per_second <= 16'd1000;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_LOCKOUT_SECONDS:  cfg_q.lockout_seconds  <= cfg_data[7:0];
				REG_FAILURE_LIMIT:    cfg_q.failure_limit    <= cfg_data[3:0];
				REG_LED_HOLD_MS:      cfg_q.led_hold_ms      <= cfg_data;
				REG_TICKS_PER_SECOND: cfg_q.ticks_per_second <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

@@ src/kplc_core.sv @@
module kplc_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic              func,
	input  logic [3:0]        key,
	input  kplc_pkg::cfg_t    cfg,
	output kplc_pkg::result_t res
);
	import kplc_pkg::*;

	logic [3:0]       pin_q   [PIN_DIGITS];
	logic [3:0]       buf_q   [PIN_DIGITS];
	logic [CNT_W-1:0] cnt_q;
	logic             set_q;
	logic [3:0]       fail_q;
	logic             lock_q;
	logic [7:0]       secs_q;
	logic [15:0]      tick_q;
	logic             led_q;
	logic [15:0]      ledc_q;

	logic [3:0]       pin_d   [PIN_DIGITS];
	logic [3:0]       buf_d   [PIN_DIGITS];
	logic [CNT_W-1:0] cnt_d;
	logic             set_d;
	logic [3:0]       fail_d;
	logic             lock_d;
	logic [7:0]       secs_d;
	logic [15:0]      tick_d;
	logic             led_d;
	logic [15:0]      ledc_d;
	event_t           ev;
	sound_t           snd;

	always_comb begin
		logic        match;
		logic [15:0] limit;
		logic [15:0] tick_inc;
		logic [15:0] packed_digits;

		for (int i = 0; i < PIN_DIGITS; i++) begin
			pin_d[i] = pin_q[i];
			buf_d[i] = buf_q[i];
		end
		cnt_d  = cnt_q;
		set_d  = set_q;
		fail_d = fail_q;
		lock_d = lock_q;
		secs_d = secs_q;
		tick_d = tick_q;
		led_d  = led_q;
		ledc_d = ledc_q;
		ev     = EV_NONE;
		snd    = SND_NONE;

		match = 1'b1;
		for (int i = 0; i < PIN_DIGITS; i++)
			if (buf_q[i] != pin_q[i])
				match = 1'b0;
		limit    = (cfg.ticks_per_second == 16'd0) ? 16'd1 : cfg.ticks_per_second;
		tick_inc = tick_q + 16'd1;

		if (func == FUNC_TICK) begin
			if (lock_q) begin
				if (secs_q != 8'd0) begin
					if (tick_inc >= limit) begin
						tick_d = 16'd0;
						secs_d = secs_q - 8'd1;
					end else begin
						tick_d = tick_inc;
					end
				end else begin
					lock_d = 1'b0;
					tick_d = 16'd0;
					fail_d = 4'd0;
					cnt_d  = '0;
					led_d  = 1'b0;
					ledc_d = 16'd0;
					ev     = EV_UNLOCK;
				end
			end else if (ledc_q != 16'd0) begin
				ledc_d = ledc_q - 16'd1;
				if (ledc_q == 16'd1)
					led_d = 1'b0;
			end
		end else if (lock_q) begin
			ev = EV_IGNORED;
		end else if (key <= KEY_DIGIT_MAX) begin
			snd = SND_CLICK;
			if (cnt_q < CNT_W'(PIN_DIGITS)) begin
				for (int i = 0; i < PIN_DIGITS; i++)
					if (cnt_q == CNT_W'(i))
						buf_d[i] = key;
				cnt_d = cnt_q + CNT_W'(1);
				ev    = EV_EDIT;
			end
		end else if (key == KEY_DEL) begin
			snd = SND_CLICK;
			if (cnt_q != '0) begin
				cnt_d = cnt_q - CNT_W'(1);
				ev    = EV_EDIT;
			end
		end else if (key == KEY_CLR) begin
			cnt_d  = '0;
			led_d  = 1'b0;
			ledc_d = 16'd0;
			if (set_q) begin
				for (int i = 0; i < PIN_DIGITS; i++)
					pin_d[i] = 4'd0;
				set_d = 1'b0;
				snd   = SND_CONFIRM;
				ev    = EV_ZERO;
			end else begin
				snd = SND_CLICK;
				ev  = EV_CLEAR;
			end
		end else if (key == KEY_SET) begin
			set_d  = 1'b1;
			cnt_d  = '0;
			led_d  = 1'b0;
			ledc_d = 16'd0;
			snd    = SND_SET;
			ev     = EV_SETMODE;
		end else if (key == KEY_OK) begin
			cnt_d = '0;
			if (cnt_q == CNT_W'(PIN_DIGITS) && set_q) begin
				for (int i = 0; i < PIN_DIGITS; i++)
					pin_d[i] = buf_q[i];
				set_d  = 1'b0;
				led_d  = 1'b0;
				ledc_d = 16'd0;
				snd    = SND_DOUBLE;
				ev     = EV_SAVE;
			end else if (cnt_q == CNT_W'(PIN_DIGITS) && match) begin
				fail_d = 4'd0;
				ledc_d = cfg.led_hold_ms;
				led_d  = (cfg.led_hold_ms != 16'd0);
				snd    = SND_MELODY;
				ev     = EV_GRANT;
			end else begin
				// failed check or short entry
				if (fail_q != 4'd15)
					fail_d = fail_q + 4'd1;
				led_d  = 1'b0;
				ledc_d = 16'd0;
				if (fail_q >= cfg.failure_limit) begin
					lock_d = 1'b1;
					secs_d = cfg.lockout_seconds;
					tick_d = 16'd0;
					snd    = SND_NONE;
					ev     = EV_LOCK;
				end else begin
					snd = SND_WRONG;
					ev  = EV_DENY;
				end
			end
		end

		packed_digits = 16'd0;
		for (int i = 0; i < SLOTS; i++)
			if (CNT_W'(i) < cnt_d)
				packed_digits[4*i +: 4] = buf_d[i];

		res.ev             = ev;
		res.snd            = snd;
		res.led_lit        = led_d;
		res.locked         = lock_d;
		res.seconds_left   = lock_d ? secs_d : 8'd0;
		res.entered_count  = 3'(cnt_d);
		res.entered_digits = packed_digits;
		res.in_set_mode    = set_d;
		res.failures       = fail_d;
	end

	// entry digits hold no reset; slots past the count are never shown
	always_ff @(posedge clk) begin
		if (fire)
			for (int i = 0; i < PIN_DIGITS; i++)
				buf_q[i] <= buf_d[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIN_DIGITS; i++)
				pin_q[i] <= 4'd0;
			cnt_q  <= '0;
			set_q  <= 1'b0;
			fail_q <= 4'd0;
			lock_q <= 1'b0;
			secs_q <= 8'd0;
			tick_q <= 16'd0;
			led_q  <= 1'b0;
			ledc_q <= 16'd0;
		end else if (fire) begin
			for (int i = 0; i < PIN_DIGITS; i++)
				pin_q[i] <= pin_d[i];
			cnt_q  <= cnt_d;
			set_q  <= set_d;
			fail_q <= fail_d;
			lock_q <= lock_d;
			secs_q <= secs_d;
			tick_q <= tick_d;
			led_q  <= led_d;
			ledc_q <= ledc_d;
		end
	end

endmodule

@@ src/keypad_pin_lock_controller.sv @@
// Channel   Handshake              Payload
// item      item_valid/item_stall  func, key_code
// result    res_valid/res_stall    event_res .. failures (nine status fields)
// config    cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One item per cycle sustained while the result is not stalled. A transferred item sits
// in the input register until it is evaluated, which loads the result register; the
// result transfers from there.
// The whole update is one combinational pass between input and result registers.
// arst_n clears all control state and the stored PIN; config returns to defaults.
// A stalled result holds the output register; the input register still takes one
// more item, and item_stall rises only when both registers are occupied.
module keypad_pin_lock_controller (
	input  logic        clk,
	input  logic        arst_n,
	// item channel
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        func,
	input  logic [3:0]  key_code,
	// result channel
	output logic        res_valid,
	input  logic        res_stall,
	output logic [3:0]  event_res,
	output logic [2:0]  sound,
	output logic        led_lit,
	output logic        locked,
	output logic [7:0]  seconds_left,
	output logic [2:0]  entered_count,
	output logic [15:0] entered_digits,
	output logic        in_set_mode,
	output logic [3:0]  failures,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import kplc_pkg::*;

	cfg_t       cfg;
	result_t    res_next;
	result_t    res_q;
	logic       res_valid_q;

	// input register
	logic       item_valid_s1;
	logic       func_s1;
	logic [3:0] key_s1;

	logic       advance;   // result register free or being drained
	logic       fire;      // item in s1 is evaluated this cycle
	logic       accept;    // item transfer on the input side

	assign advance    = !res_valid_q || !res_stall;
	assign fire       = item_valid_s1 && advance;
	assign item_stall = item_valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	kplc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.cfg       (cfg)
	);

	kplc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.func   (func_s1),
		.key    (key_s1),
		.cfg    (cfg),
		.res    (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (accept) begin
			item_valid_s1 <= 1'b1;
		end else if (fire) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= func;
			key_s1  <= key_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			res_q <= res_next;
	end

	assign res_valid      = res_valid_q;
	assign event_res      = res_q.ev;
	assign sound          = res_q.snd;
	assign led_lit        = res_q.led_lit;
	assign locked         = res_q.locked;
	assign seconds_left   = res_q.seconds_left;
	assign entered_count  = res_q.entered_count;
	assign entered_digits = res_q.entered_digits;
	assign in_set_mode    = res_q.in_set_mode;
	assign failures       = res_q.failures;

endmodule

@@ src/kplc_checker.sv @@
module kplc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_stall,
	input logic [3:0]  event_res,
	input logic [2:0]  sound,
	input logic        led_lit,
	input logic        locked,
	input logic [2:0]  entered_count,
	input logic [15:0] entered_digits,
	input logic [3:0]  failures
);
	import kplc_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(event_res) && $stable(entered_digits))
		else $error("result changed while stalled");

	a_led_not_locked: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(led_lit && locked))
		else $error("LED lit during lockout");

	a_lock_start: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && event_res == EV_LOCK |->
			locked && sound == SND_NONE && entered_count == 3'd0)
		else $error("lockout start with wrong status");

	a_grant: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && event_res == EV_GRANT |->
			!locked && failures == 4'd0 && entered_count == 3'd0 && sound == SND_MELODY)
		else $error("grant with wrong status");

endmodule

bind keypad_pin_lock_controller kplc_checker u_kplc_checker (.*);

@@ tb/testbench.sv @@
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import kplc_pkg::*;

	localparam int CLK_PERIOD     = 12;
	localparam int RESET_CYCLES   = 6;
	// no transfer on any channel for this many cycles means the block is hung
	localparam int WATCHDOG_LIMIT = 4000;
	// result passes the input and result registers after the item transfer; leave a little margin
	localparam int TAIL_CYCLES    = 8;
	localparam int MAX_GAP        = 64;
	localparam int REPORT_LIMIT   = 10;

	localparam logic       FUNC_KEY  = ~FUNC_TICK;
	// codes above the delete key are not assigned to any key
	localparam logic [3:0] KEY_SPARE_LO = 4'd14;
	localparam logic [3:0] KEY_SPARE_HI = 4'd15;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic        func       = 1'b0;
	logic [3:0]  key_code   = '0;
	logic        res_valid;
	logic        res_stall  = 1'b0;
	logic [3:0]  event_res;
	logic [2:0]  sound;
	logic        led_lit;
	logic        locked;
	logic [7:0]  seconds_left;
	logic [2:0]  entered_count;
	logic [15:0] entered_digits;
	logic        in_set_mode;
	logic [3:0]  failures;
	logic        cfg_valid  = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index  = '0;
	logic [15:0] cfg_data   = '0;

	keypad_pin_lock_controller DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.func           (func),
		.key_code       (key_code),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.event_res      (event_res),
		.sound          (sound),
		.led_lit        (led_lit),
		.locked         (locked),
		.seconds_left   (seconds_left),
		.entered_count  (entered_count),
		.entered_digits (entered_digits),
		.in_set_mode    (in_set_mode),
		.failures       (failures),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ---------------------------------------------------------------------
	// Shadow copy of the lock: settings and state, at reset values.
	// ---------------------------------------------------------------------
	cfg_t lock_cfg = '{
		lockout_seconds:  8'd10,
		failure_limit:    4'd3,
		led_hold_ms:      16'd1200,
		ticks_per_second: 16'd1000
	};

	logic [3:0]  pin_code [PIN_DIGITS] = '{default: '0};
	logic [3:0]  entry    [PIN_DIGITS] = '{default: '0};
	int          entry_len    = 0;
	logic        setting_pin  = 1'b0;
	logic [3:0]  failed_tries = '0;
	logic        lockout_on   = 1'b0;
	logic [7:0]  secs_left    = '0;
	logic [15:0] sub_tick     = '0;
	logic        led_on       = 1'b0;
	logic [15:0] led_ms_left  = '0;

	// responses owed by the block, oldest first
	result_t responses_due [$];

	// knobs for the idle patterns, in percent
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	int keys_and_ticks = 0;   // transfers whose event is not EV_IGNORED
	int mismatches     = 0;

	// Apply one key press or tick to the shadow state and return what the
	// block must answer with. Output fields reflect the state after the item.
	function automatic result_t keypad_response(input logic is_tick, input logic [3:0] key);
		result_t     resp;
		logic [15:0] rate;
		logic        pin_ok;
		logic        lock_now;
		int          i;
		resp     = '0;
		resp.ev  = EV_NONE;
		resp.snd = SND_NONE;
		if (is_tick == FUNC_TICK) begin
			if (lockout_on) begin
				if (secs_left != 0) begin
					// a zero rate still counts one tick per second
					rate = (lock_cfg.ticks_per_second == 0) ? 16'd1 : lock_cfg.ticks_per_second;
					sub_tick = sub_tick + 16'd1;
					if (sub_tick >= rate) begin
						sub_tick  = '0;
						secs_left = secs_left - 8'd1;
					end
				end else begin
					// first tick at zero seconds releases the lock
					lockout_on   = 1'b0;
					sub_tick     = '0;
					failed_tries = '0;
					entry_len    = 0;
					led_on       = 1'b0;
					led_ms_left  = '0;
					resp.ev      = EV_UNLOCK;
				end
			end else if (led_ms_left != 0) begin
				led_ms_left = led_ms_left - 16'd1;
				if (led_ms_left == 0)
					led_on = 1'b0;
			end
		end else if (lockout_on) begin
			resp.ev = EV_IGNORED;
		end else begin
			resp.snd = SND_CLICK;
			if (key <= KEY_DIGIT_MAX) begin
				// full entry: click only
				if (entry_len < PIN_DIGITS) begin
					entry[entry_len] = key;
					entry_len++;
					resp.ev = EV_EDIT;
				end
			end else if (key == KEY_DEL) begin
				if (entry_len > 0) begin
					entry_len--;
					resp.ev = EV_EDIT;
				end
			end else if (key == KEY_CLR) begin
				entry_len   = 0;
				led_on      = 1'b0;
				led_ms_left = '0;
				if (setting_pin) begin
					pin_code    = '{default: '0};
					setting_pin = 1'b0;
					resp.snd    = SND_CONFIRM;
					resp.ev     = EV_ZERO;
				end else begin
					resp.ev = EV_CLEAR;
				end
			end else if (key == KEY_SET) begin
				setting_pin = 1'b1;
				entry_len   = 0;
				led_on      = 1'b0;
				led_ms_left = '0;
				resp.snd    = SND_SET;
				resp.ev     = EV_SETMODE;
			end else if (key == KEY_OK) begin
				pin_ok = (entry_len == PIN_DIGITS);
				for (i = 0; i < PIN_DIGITS; i++)
					if (entry[i] != pin_code[i])
						pin_ok = 1'b0;
				if (entry_len == PIN_DIGITS && setting_pin) begin
					pin_code    = entry;
					setting_pin = 1'b0;
					entry_len   = 0;
					led_on      = 1'b0;
					led_ms_left = '0;
					resp.snd    = SND_DOUBLE;
					resp.ev     = EV_SAVE;
				end else if (pin_ok) begin
					entry_len    = 0;
					failed_tries = '0;
					led_ms_left  = lock_cfg.led_hold_ms;
					led_on       = (lock_cfg.led_hold_ms != 0);
					resp.snd     = SND_MELODY;
					resp.ev      = EV_GRANT;
				end else begin
					// wrong or short entry; locks once the count already sits at the limit
					lock_now = (failed_tries >= lock_cfg.failure_limit);
					if (failed_tries != 4'd15)
						failed_tries = failed_tries + 4'd1;
					entry_len   = 0;
					led_on      = 1'b0;
					led_ms_left = '0;
					if (lock_now) begin
						lockout_on = 1'b1;
						secs_left  = lock_cfg.lockout_seconds;
						sub_tick   = '0;
						resp.snd   = SND_NONE;
						resp.ev    = EV_LOCK;
					end else begin
						resp.snd = SND_WRONG;
						resp.ev  = EV_DENY;
					end
				end
			end else begin
				// spare codes do nothing at all
				resp.snd = SND_NONE;
			end
		end
		resp.led_lit       = led_on;
		resp.locked        = lockout_on;
		resp.seconds_left  = lockout_on ? secs_left : 8'd0;
		resp.entered_count = 3'(entry_len);
		for (i = 0; i < SLOTS; i++)
			if (i < entry_len)
				resp.entered_digits[4 * i +: 4] = entry[i];
		resp.in_set_mode = setting_pin;
		resp.failures    = failed_tries;
		return resp;
	endfunction

	function automatic string show(input result_t r);
		return $sformatf("ev=%0d snd=%0d led=%0b lock=%0b secs=%0d cnt=%0d digits=%h set=%0b fails=%0d",
			r.ev, r.snd, r.led_lit, r.locked, r.seconds_left, r.entered_count,
			r.entered_digits, r.in_set_mode, r.failures);
	endfunction

	function automatic void note_failure(input string msg);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("%t  %s", $realtime, msg);
	endfunction

	// ---------------------------------------------------------------------
	// Result side: random stall, and every result transfer is checked
	// against the oldest owed response. Stall is sampled before it is
	// redrawn, so the check sees the value the block saw at this edge.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : result_monitor
		result_t seen;
		result_t want;
		string   bad;
		if (arst_n && res_valid && !res_stall) begin
			seen.ev             = event_t'(event_res);
			seen.snd            = sound_t'(sound);
			seen.led_lit        = led_lit;
			seen.locked         = locked;
			seen.seconds_left   = seconds_left;
			seen.entered_count  = entered_count;
			seen.entered_digits = entered_digits;
			seen.in_set_mode    = in_set_mode;
			seen.failures       = failures;
			if (responses_due.size() == 0) begin
				note_failure($sformatf("result with nothing owed: %s", show(seen)));
			end else begin
				want = responses_due.pop_front();
				bad  = "";
				if (seen.ev !== want.ev)                         bad = {bad, " event_res"};
				if (seen.snd !== want.snd)                       bad = {bad, " sound"};
				if (seen.led_lit !== want.led_lit)               bad = {bad, " led_lit"};
				if (seen.locked !== want.locked)                 bad = {bad, " locked"};
				if (seen.seconds_left !== want.seconds_left)     bad = {bad, " seconds_left"};
				if (seen.entered_count !== want.entered_count)   bad = {bad, " entered_count"};
				if (seen.entered_digits !== want.entered_digits) bad = {bad, " entered_digits"};
				if (seen.in_set_mode !== want.in_set_mode)       bad = {bad, " in_set_mode"};
				if (seen.failures !== want.failures)             bad = {bad, " failures"};
				if (bad != "")
					note_failure($sformatf("mismatch in%s\n  expected %s\n  actual   %s",
						bad, show(want), show(seen)));
			end
		end
		res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// Hang detector: counts edges with no transfer on any channel.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (res_valid && !res_stall) ||
			    (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Item side. Valid stays high after a transfer so back-to-back items
	// never see a low/high pair in one step; it drops only for a gap or a
	// drain. The shadow state advances at the transfer edge.
	// ---------------------------------------------------------------------
	task automatic send_item(input logic is_tick, input logic [3:0] key);
		int      gap;
		result_t resp;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		func       <= is_tick;
		key_code   <= key;
		do @(posedge clk); while (item_stall);
		resp = keypad_response(is_tick, key);
		responses_due.push_back(resp);
		if (resp.ev != EV_IGNORED)
			keys_and_ticks++;
	endtask

	// Sender holds off until the block owes nothing; one result per item,
	// so an empty list means the block is idle.
	task automatic drain_results();
		item_valid <= 1'b0;
		do @(posedge clk); while (responses_due.size() != 0);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_LOCKOUT_SECONDS:  lock_cfg.lockout_seconds  = data[7:0];
			REG_FAILURE_LIMIT:    lock_cfg.failure_limit    = data[3:0];
			REG_LED_HOLD_MS:      lock_cfg.led_hold_ms      = data;
			REG_TICKS_PER_SECOND: lock_cfg.ticks_per_second = data;
			default: ;
		endcase
	endtask

	// All four registers, back to back, only with the block idle.
	task automatic configure(input logic [7:0] secs, input logic [3:0] limit,
	                         input logic [15:0] hold, input logic [15:0] rate);
		drain_results();
		write_reg(REG_LOCKOUT_SECONDS, 16'(secs));
		write_reg(REG_FAILURE_LIMIT, 16'(limit));
		write_reg(REG_LED_HOLD_MS, hold);
		write_reg(REG_TICKS_PER_SECOND, rate);
		cfg_valid <= 1'b0;
	endtask

	task automatic press(input logic [3:0] key);
		send_item(FUNC_KEY, key);
	endtask

	task automatic press_random_digit();
		press(4'($urandom_range(0, 9)));
	endtask

	task automatic empty_entry();
		while (entry_len != 0 && !lockout_on)
			press(KEY_DEL);
	endtask

	task automatic enter_stored_pin();
		int i;
		empty_entry();
		for (i = 0; i < PIN_DIGITS; i++)
			press(pin_code[i]);
		press(KEY_OK);
	endtask

	// ---------------------------------------------------------------------
	// Directed tests
	// ---------------------------------------------------------------------

	// Delete on empty entry, spare codes, digits at both ends, delete, full entry.
	task automatic test_entry_editing();
		configure(8'd1, 4'd1, 16'd0, 16'd0);
		press(KEY_DEL);
		press(KEY_SPARE_LO);
		press(KEY_SPARE_HI);
		press(KEY_DIGIT_MAX);
		press(KEY_DEL);
		repeat (PIN_DIGITS) press(4'd0);
		press(4'd5);
	endtask

	// Grant against the all-zero PIN with zero LED hold, save a new PIN,
	// then a short entry counts as a failure.
	task automatic test_pin_check();
		press(KEY_OK);
		press(KEY_SET);
		press(KEY_DIGIT_MAX);
		press(4'd8);
		press(4'd7);
		press(4'd6);
		press(KEY_OK);
		press(KEY_OK);
	endtask

	// Second failure at limit one locks; keys are ignored; zero rate acts
	// as one tick per second; the tick at zero seconds unlocks.
	task automatic test_lockout();
		press(KEY_OK);
		press(4'd3);
		send_item(FUNC_TICK, '0);
		send_item(FUNC_TICK, KEY_SPARE_HI);
	endtask

	// Clear key in set mode wipes the PIN; outside set mode it just clears.
	task automatic test_pin_zeroing();
		press(KEY_SET);
		press(KEY_CLR);
		press(4'd1);
		press(KEY_CLR);
	endtask

	// ---------------------------------------------------------------------
	// Random traffic: mostly complete key sequences, some noise. While
	// locked, mostly ticks so the lockout runs out.
	// ---------------------------------------------------------------------
	task automatic random_sequence();
		int pick;
		pick = $urandom_range(0, 15);
		if (lockout_on) begin
			if (pick == 0)
				press(4'($urandom_range(0, 15)));
			else
				repeat ($urandom_range(1, 8)) send_item(FUNC_TICK, 4'($urandom_range(0, 15)));
		end else begin
			case (pick)
				0, 1, 2, 3, 4: enter_stored_pin();
				5, 6: begin
					empty_entry();
					repeat (PIN_DIGITS) press_random_digit();
					press(KEY_OK);
				end
				7: begin
					press(KEY_SET);
					repeat (PIN_DIGITS) press_random_digit();
					press(KEY_OK);
				end
				8: begin
					empty_entry();
					repeat ($urandom_range(0, PIN_DIGITS - 1)) press_random_digit();
					press(KEY_OK);
				end
				9: begin
					// edit in the middle, then overfill
					press_random_digit();
					press_random_digit();
					press(KEY_DEL);
					repeat (PIN_DIGITS) press_random_digit();
					press(KEY_OK);
				end
				10: begin
					if ($urandom_range(0, 1))
						press(KEY_SET);
					press(KEY_CLR);
				end
				11, 12: repeat ($urandom_range(1, 6)) send_item(FUNC_TICK, 4'($urandom_range(0, 15)));
				13: begin
					// LED lit where the hold allows, then cut short by one of the keys that clear it
					enter_stored_pin();
					send_item(FUNC_TICK, '0);
					case ($urandom_range(0, 2))
						0: press(KEY_SET);
						1: press(KEY_CLR);
						default: press(KEY_OK);
					endcase
				end
				default: send_item(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
			endcase
		end
	endtask

	task automatic run_phase(input logic [7:0] secs, input logic [3:0] limit,
	                         input logic [15:0] hold, input logic [15:0] rate,
	                         input int idle_pct, input int stall_pct, input int count);
		int target;
		configure(secs, limit, hold, rate);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		target = keys_and_ticks + count;
		while (keys_and_ticks < target)
			random_sequence();
	endtask

	task automatic test_random_traffic();
		// no idling on either side
		run_phase(8'd2, 4'd2, 16'd4, 16'd3, 0, 0, 350);
		// sender mostly idle; longest lockout, limit of one, longest hold
		run_phase(8'd255, 4'd1, 16'hFFFF, 16'd1, 88, 0, 350);
		// receiver mostly stalled; zero lockout and zero rate, highest limit
		run_phase(8'd0, 4'd15, 16'd0, 16'd0, 0, 88, 350);
		// light idling on both sides; slowest tick rate
		run_phase(8'd1, 4'd15, 16'd1, 16'hFFFF, 21, 21, 350);
		// back to full speed, default-like settings with a fast tick
		run_phase(8'd5, 4'd3, 16'd1200, 16'd2, 0, 0, 350);
	endtask

	// ---------------------------------------------------------------------
	// Sequence: one reset, directed tests, random traffic, drain, verdict.
	// ---------------------------------------------------------------------
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		test_entry_editing();
		test_pin_check();
		test_lockout();
		test_pin_zeroing();
		test_random_traffic();
		drain_results();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (responses_due.size() != 0)
			note_failure($sformatf("%0d responses never arrived", responses_due.size()));
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ filelist.f @@
src/kplc_pkg.sv
src/kplc_cfg.sv
src/kplc_core.sv
src/keypad_pin_lock_controller.sv
src/kplc_checker.sv
tb/testbench.sv
